### sv/cnv3_pkg.sv
package cnv3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = COL_W + 1;
  localparam int HGT_W       = 16;
  localparam int ROW_W       = HGT_W + 1;
  localparam int EMIT_W      = 26;
  localparam int TOTAL_W     = WID_W + HGT_W;
  localparam int DIV_W       = 16;
  localparam int ACC_W       = 20;
  localparam int QUOT_W      = ACC_W - 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4,
    REG_DIVISOR      = 3'd5
  } reg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic           frame_end;
    pix_t [8:0]     px;
  } job_t;

  typedef struct packed {
    logic [WID_W-1:0]    width;
    logic [HGT_W-1:0]    height;
    logic [TOTAL_W-1:0]  total;
    logic [2:0][23:0]    coef;
    logic [DIV_W-1:0]    divisor;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_EXEC
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MAC,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

### sv/cnv3_front.sv
module cnv3_front (
  input  logic               clk,
  input  logic               rst,
  input  cnv3_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  cnv3_pkg::in_item_t in_data,
  input  cnv3_pkg::q_stat_t  qstat,
  output logic               push,
  output cnv3_pkg::job_t     job
);

  cnv3_pkg::front_state_t state, state_next;
  cnv3_pkg::in_item_t     item;
  logic [cnv3_pkg::COL_W-1:0]  col;
  logic [cnv3_pkg::ROW_W-1:0]  row;
  logic [cnv3_pkg::EMIT_W-1:0] emitted;
  cnv3_pkg::pix_t win [9];
  cnv3_pkg::pix_t nwin [9];
  cnv3_pkg::pix_t src [9];
  cnv3_pkg::pix_t rd_u, rd_m;
  cnv3_pkg::pix_t upper_mem [cnv3_pkg::MAX_WIDTH];
  cnv3_pkg::pix_t middle_mem [cnv3_pkg::MAX_WIDTH];

  logic                        is_drain, reject, emit, col_last, fe, stall_q, advance, mem_we;
  logic                        tclamp, bclamp;
  logic [cnv3_pkg::ROW_W-1:0]  h_ext;
  logic [cnv3_pkg::EMIT_W-1:0] e_next;
  cnv3_pkg::pix_t              pix_in;
  logic [1:0]                  colsel [3];
  logic [1:0]                  rowsel [3];
  logic [3:0]                  idx;

  assign in_stall = (state != cnv3_pkg::F_IDLE);

  // Line stores: read in the read state ahead of the update, written back during the update cycle.
  always_ff @(posedge clk) begin
    if (state == cnv3_pkg::F_READ) begin
      rd_u <= upper_mem[col];
      rd_m <= middle_mem[col];
    end
    if (mem_we) begin
      upper_mem[col]  <= rd_m;
      middle_mem[col] <= pix_in;
    end
  end

  always_comb begin
    is_drain = (item.cmd == cnv3_pkg::CMD_DRAIN);
    pix_in   = is_drain ? '0 : {item.in_red, item.in_green, item.in_blue};
    h_ext    = cnv3_pkg::ROW_W'(cfg.height);
    reject   = is_drain ? (row < h_ext) : (row >= h_ext);
    emit     = (row >= cnv3_pkg::ROW_W'(2)) ||
               ((row == cnv3_pkg::ROW_W'(1)) && (col != '0));
    col_last = ({1'b0, col} + cnv3_pkg::WID_W'(1)) >= cfg.width;
    e_next   = emitted + cnv3_pkg::EMIT_W'(1);
    fe       = (e_next >= cfg.total);
    stall_q  = emit && qstat.full;
    advance  = (state == cnv3_pkg::F_EXEC) && !reject && !stall_q;
    mem_we   = advance && !is_drain;
    push     = advance && emit;

    for (int k = 0; k < 6; k++) begin
      nwin[k] = win[k+3];
    end
    nwin[6] = rd_u;
    nwin[7] = rd_m;
    nwin[8] = pix_in;

    // At the first column the pending pixel is the last one of the previous
    // row, taken from the window before it shifts.
    if (col == '0) begin
      for (int k = 0; k < 9; k++) begin
        src[k] = win[k];
      end
      colsel[0] = (cfg.width == cnv3_pkg::WID_W'(1)) ? 2'd2 : 2'd1;
      colsel[1] = 2'd2;
      colsel[2] = 2'd2;
      tclamp    = (row == cnv3_pkg::ROW_W'(2));
      bclamp    = (row >= h_ext + cnv3_pkg::ROW_W'(1));
    end else begin
      for (int k = 0; k < 9; k++) begin
        src[k] = nwin[k];
      end
      colsel[0] = (col == cnv3_pkg::COL_W'(1)) ? 2'd1 : 2'd0;
      colsel[1] = 2'd1;
      colsel[2] = ({1'b0, col} >= cfg.width) ? 2'd1 : 2'd2;
      tclamp    = (row == cnv3_pkg::ROW_W'(1));
      bclamp    = (row >= h_ext);
    end
    rowsel[0] = tclamp ? 2'd1 : 2'd0;
    rowsel[1] = 2'd1;
    rowsel[2] = bclamp ? 2'd1 : 2'd2;

    job.frame_end = fe;
    idx           = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        idx            = 4'(colsel[c] * 3 + rowsel[r]);
        job.px[r*3+c]  = src[idx];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cnv3_pkg::F_IDLE: begin
        if (in_valid) state_next = cnv3_pkg::F_READ;
      end
      cnv3_pkg::F_READ: begin
        state_next = cnv3_pkg::F_EXEC;
      end
      cnv3_pkg::F_EXEC: begin
        if (reject) begin
          state_next = cnv3_pkg::F_IDLE;
        end else if (!stall_q) begin
          // A drain tick that finds nothing pending steps once more.
          state_next = (is_drain && !emit) ? cnv3_pkg::F_READ : cnv3_pkg::F_IDLE;
        end
      end
      default: state_next = cnv3_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == cnv3_pkg::F_IDLE && in_valid) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cnv3_pkg::F_IDLE;
      col     <= '0;
      row     <= '0;
      emitted <= '0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (advance) begin
        for (int k = 0; k < 9; k++) begin
          win[k] <= nwin[k];
        end
        if (emit && fe) begin
          col     <= '0;
          row     <= '0;
          emitted <= '0;
        end else begin
          if (col_last) begin
            col <= '0;
            row <= row + cnv3_pkg::ROW_W'(1);
          end else begin
            col <= col + cnv3_pkg::COL_W'(1);
          end
          if (emit) emitted <= e_next;
        end
      end
    end
  end

endmodule

### sv/cnv3_queue.sv
module cnv3_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cnv3_pkg::job_t    wdata,
  input  logic              pop,
  output cnv3_pkg::job_t    rdata,
  output cnv3_pkg::q_stat_t stat
);

  localparam int PTR_W = (cnv3_pkg::QUEUE_DEPTH > 1) ? $clog2(cnv3_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cnv3_pkg::QUEUE_DEPTH + 1);

  cnv3_pkg::job_t    slots [cnv3_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [CNT_W-1:0]  count;

  assign rdata      = slots[rp];
  assign stat.full  = (count == CNT_W'(cnv3_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(cnv3_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= (rp == PTR_W'(cnv3_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### sv/cnv3_back.sv
module cnv3_back (
  input  logic                clk,
  input  logic                rst,
  input  cnv3_pkg::cfg_t      cfg,
  input  cnv3_pkg::q_stat_t   qstat,
  output logic                pop,
  input  cnv3_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_stall,
  output cnv3_pkg::out_item_t out_data
);

  cnv3_pkg::back_state_t state, state_next;
  cnv3_pkg::job_t        jreg;
  logic [3:0]            tap;
  logic [1:0]            trow, tcol;
  logic [4:0]            cnt;
  logic signed [cnv3_pkg::ACC_W-1:0] acc [3];
  logic [cnv3_pkg::QUOT_W-1:0]       dvd [3];
  logic [cnv3_pkg::DIV_W:0]          rem [3];
  logic [2:0]                        neg;

  logic [cnv3_pkg::DIV_W-1:0]        d_eff;
  logic [cnv3_pkg::DIV_W:0]          d_ext;
  cnv3_pkg::pix_t                    px;
  logic [23:0]                       coef_row;
  logic signed [7:0]                 wt;
  logic signed [16:0]                prod [3];
  logic [cnv3_pkg::DIV_W:0]          trial [3];
  logic [2:0]                        ge;
  logic [7:0]                        chan [3];
  logic                              mac_last, div_last;

  assign pop       = (state == cnv3_pkg::B_IDLE) && !qstat.empty;
  assign out_valid = (state == cnv3_pkg::B_OUT);
  assign mac_last  = (tap == 4'd8);
  assign div_last  = (cnt == 5'(cnv3_pkg::QUOT_W - 1));

  always_comb begin
    d_eff    = (cfg.divisor == '0) ? cnv3_pkg::DIV_W'(1) : cfg.divisor;
    d_ext    = {1'b0, d_eff};
    px       = jreg.px[tap];
    coef_row = cfg.coef[trow];
    wt       = $signed(coef_row[tcol*8 +: 8]);
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]  = $signed({1'b0, px[ch*8 +: 8]}) * wt;
      trial[ch] = {rem[ch][cnv3_pkg::DIV_W-1:0], dvd[ch][cnv3_pkg::QUOT_W-1]};
      ge[ch]    = (trial[ch] >= d_ext);
      // A negative sum truncates to zero or below, so it always clamps to zero.
      if (neg[ch]) begin
        chan[ch] = 8'd0;
      end else if (dvd[ch] > cnv3_pkg::QUOT_W'(255)) begin
        chan[ch] = 8'd255;
      end else begin
        chan[ch] = dvd[ch][7:0];
      end
    end
    out_data.out_blue  = chan[0];
    out_data.out_green = chan[1];
    out_data.out_red   = chan[2];
    out_data.frame_end = jreg.frame_end;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cnv3_pkg::B_IDLE: if (!qstat.empty) state_next = cnv3_pkg::B_MAC;
      cnv3_pkg::B_MAC:  if (mac_last) state_next = cnv3_pkg::B_PREP;
      cnv3_pkg::B_PREP: state_next = cnv3_pkg::B_DIV;
      cnv3_pkg::B_DIV:  if (div_last) state_next = cnv3_pkg::B_OUT;
      cnv3_pkg::B_OUT:  if (!out_stall) state_next = cnv3_pkg::B_IDLE;
      default:          state_next = cnv3_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) jreg <= job;
    unique case (state)
      cnv3_pkg::B_IDLE: begin
        tap  <= '0;
        trow <= '0;
        tcol <= '0;
        for (int ch = 0; ch < 3; ch++) acc[ch] <= '0;
      end
      cnv3_pkg::B_MAC: begin
        for (int ch = 0; ch < 3; ch++) begin
          acc[ch] <= acc[ch] + cnv3_pkg::ACC_W'(prod[ch]);
        end
        tap <= tap + 4'd1;
        if (tcol == 2'd2) begin
          tcol <= '0;
          trow <= trow + 2'd1;
        end else begin
          tcol <= tcol + 2'd1;
        end
      end
      cnv3_pkg::B_PREP: begin
        cnt <= '0;
        for (int ch = 0; ch < 3; ch++) begin
          neg[ch] <= acc[ch][cnv3_pkg::ACC_W-1];
          dvd[ch] <= acc[ch][cnv3_pkg::QUOT_W-1:0];
          rem[ch] <= '0;
        end
      end
      cnv3_pkg::B_DIV: begin
        cnt <= cnt + 5'd1;
        for (int ch = 0; ch < 3; ch++) begin
          rem[ch] <= ge[ch] ? trial[ch] - d_ext : trial[ch];
          dvd[ch] <= {dvd[ch][cnv3_pkg::QUOT_W-2:0], ge[ch]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnv3_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/conv3x3_clamped_edges_unit.sv
// 3x3 convolution of an RGB raster stream with edges clamped to the nearest
// row or column. Each result is the signed weighted sum per channel divided by
// the divisor (truncated toward zero) and clamped to 0..255; results lag input
// by one row plus one pixel, and drain ticks after the last row flush them.
// The front part takes each transaction through an accept state, a line-store
// read state and an update state, waiting in the update state while the queue
// is full; a drain tick that finds nothing pending runs the read and update
// states a second time. The back part takes a job from the queue, does the
// multiply-accumulate, a setup step, the bit-serial divider and the output
// step, and this sets the sustained output rate. A two-entry queue between
// the parts lets the front run ahead while results wait.
module conv3x3_clamped_edges_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [2:0]          cfg_idx,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  cnv3_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cnv3_pkg::out_item_t out_data
);

  logic [10:0]                   image_width;
  logic [cnv3_pkg::HGT_W-1:0]    image_height;
  logic [23:0]                   coef_top_row, coef_mid_row, coef_bottom_row;
  logic [cnv3_pkg::DIV_W-1:0]    divisor;
  logic [cnv3_pkg::TOTAL_W-1:0]  total;
  logic [cnv3_pkg::WID_W-1:0]    eff_w;
  logic [cnv3_pkg::HGT_W-1:0]    eff_h;
  cnv3_pkg::cfg_t                cfg;
  cnv3_pkg::q_stat_t             qstat;
  cnv3_pkg::job_t                push_job, pop_job;
  logic                          push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 11'd1024;
      image_height    <= 16'd1024;
      coef_top_row    <= 24'h010101;
      coef_mid_row    <= 24'h010101;
      coef_bottom_row <= 24'h010101;
      divisor         <= 16'd9;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        cnv3_pkg::REG_IMAGE_WIDTH:  image_width     <= cfg_wdata[10:0];
        cnv3_pkg::REG_IMAGE_HEIGHT: image_height    <= cfg_wdata[15:0];
        cnv3_pkg::REG_COEF_TOP:     coef_top_row    <= cfg_wdata;
        cnv3_pkg::REG_COEF_MID:     coef_mid_row    <= cfg_wdata;
        cnv3_pkg::REG_COEF_BOTTOM:  coef_bottom_row <= cfg_wdata;
        cnv3_pkg::REG_DIVISOR:      divisor         <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = cnv3_pkg::WID_W'(1);
    end else if (int'(image_width) > cnv3_pkg::MAX_WIDTH) begin
      eff_w = cnv3_pkg::WID_W'(cnv3_pkg::MAX_WIDTH);
    end else begin
      eff_w = cnv3_pkg::WID_W'(image_width);
    end
    eff_h = (image_height == '0) ? cnv3_pkg::HGT_W'(1) : image_height;
  end

  // Pixels per image, kept registered so the multiply stays off the item path.
  always_ff @(posedge clk) begin
    total <= cnv3_pkg::TOTAL_W'(eff_w) * cnv3_pkg::TOTAL_W'(eff_h);
  end

  always_comb begin
    cfg.width   = eff_w;
    cfg.height  = eff_h;
    cfg.total   = total;
    cfg.coef[0] = coef_top_row;
    cfg.coef[1] = coef_mid_row;
    cfg.coef[2] = coef_bottom_row;
    cfg.divisor = divisor;
  end

  cnv3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .job      (push_job)
  );

  cnv3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (pop_job),
    .stat  (qstat)
  );

  cnv3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .pop       (pop),
    .job       (pop_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full && !pop))
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("job popped from an empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");
`endif

endmodule
